FILE: rtl/core/tcwc_pkg.sv
// ----------------------------------------------------------------------------
// tcwc_pkg
// Shared constants and codes for the congestion window controller.
// ----------------------------------------------------------------------------
package tcwc_pkg;

    localparam int WINDOW_SLOTS = 64;
    localparam int SLOT_W       = $clog2(WINDOW_SLOTS);
    localparam int WIN_CAP_INT  = (WINDOW_SLOTS * 256 > 32767) ? 32767 : WINDOW_SLOTS * 256;
    localparam logic [15:0] WIN_CAP = WIN_CAP_INT[15:0];

    localparam logic [1:0] CMD_SEND = 2'd0;
    localparam logic [1:0] CMD_ACK  = 2'd1;
    localparam logic [1:0] CMD_TICK = 2'd2;

    localparam logic [1:0] REG_MAX_RTO  = 2'd0;
    localparam logic [1:0] REG_INIT_RTO = 2'd1;
    localparam logic [1:0] REG_DUP_LIM  = 2'd2;
    localparam logic [1:0] REG_MIN_SST  = 2'd3;

    localparam logic [9:0]  RST_MAX_RTO  = 10'd100;
    localparam logic [9:0]  RST_INIT_RTO = 10'd50;
    localparam logic [3:0]  RST_DUP_LIM  = 4'd3;
    localparam logic [6:0]  RST_MIN_SST  = 7'd2;
    localparam logic [14:0] ONE_SEGMENT  = 15'd256;
    localparam logic [6:0]  RST_THRESH   = 7'd64;

endpackage

FILE: rtl/core/tcwc_ram.sv
// ----------------------------------------------------------------------------
// tcwc_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module tcwc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/core/tcp_congestion_window_controller.sv
// ----------------------------------------------------------------------------
// tcp_congestion_window_controller
// Tahoe-style congestion window and Jacobson RTO controller.
// ----------------------------------------------------------------------------
// Usage: the s_ channel takes one command per beat (send, ack, tick) with a
// sequence or ack number. Every accepted beat yields exactly one m_ beat with
// window, threshold, RTO, retransmit request, in-flight count, may_send and
// a table-full status. The cfg channel writes the four registers; it is
// always ready and is meant to be used while the block is idle.
// Sequencing: tick, duplicate ack and unknown commands go from idle straight
// to the output state. A send scans the valid bits one slot per cycle. A new
// ack sweeps all 64 slots through the table RAMs (read, check); each freed
// slot also runs the RTT update and window growth, where avoidance uses the
// restoring divider for 256/floor(cwnd).
// Throughput: one item at a time; s_ready is high only in the idle state.
// Reset clears all control state and the valid bits; the table RAMs need no
// clearing. A stalled receiver holds the result register; the block still
// accepts a new item and parks its result until the register frees up.
// ----------------------------------------------------------------------------
module tcp_congestion_window_controller (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_command,
    input  logic [31:0] s_seq_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [14:0] m_cwnd_fixed,
    output logic [6:0]  m_slow_start_threshold,
    output logic [15:0] m_rto_fixed,
    output logic        m_retransmit,
    output logic [31:0] m_retransmit_seqno,
    output logic [6:0]  m_in_flight,
    output logic        m_may_send,
    output logic        m_status,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [9:0]  cfg_data
);
    import tcwc_pkg::*;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SCAN  = 4'd1;
    localparam logic [3:0] ST_RD    = 4'd2;
    localparam logic [3:0] ST_CHK   = 4'd3;
    localparam logic [3:0] ST_ERR   = 4'd4;
    localparam logic [3:0] ST_UPD   = 4'd5;
    localparam logic [3:0] ST_RTO   = 4'd6;
    localparam logic [3:0] ST_GROW  = 4'd7;
    localparam logic [3:0] ST_DIV   = 4'd8;
    localparam logic [3:0] ST_GADD  = 4'd9;
    localparam logic [3:0] ST_END   = 4'd10;
    localparam logic [3:0] ST_OUT   = 4'd11;

    localparam logic [SLOT_W-1:0] IDX_LAST = SLOT_W'(WINDOW_SLOTS - 1);

    logic [3:0]              state_reg, state_next;
    logic [SLOT_W-1:0]       idx_reg, idx_next;
    logic [WINDOW_SLOTS-1:0] valid_reg, valid_next;
    logic [31:0]             val_reg, val_next;
    logic [31:0]             now_reg, now_next;
    logic [14:0]             win_reg, win_next;
    logic [6:0]              thr_reg, thr_next;
    logic [15:0]             srtt_reg, srtt_next;
    logic [15:0]             dev_reg, dev_next;
    logic [15:0]             rto_reg, rto_next;
    logic [3:0]              dup_reg, dup_next;
    logic [31:0]             hack_reg, hack_next;
    logic                    run_reg, run_next;
    logic [15:0]             ela_reg, ela_next;
    logic [31:0]             old_reg, old_next;
    logic [6:0]              outst_reg, outst_next;
    logic                    match_reg, match_next;
    logic                    rex_reg, rex_next;
    logic                    stat_reg, stat_next;
    logic [31:0]             sent_reg, sent_next;
    logic [15:0]             smp_reg, smp_next;
    logic [15:0]             err_reg, err_next;
    logic [8:0]              rem_reg, rem_next;
    logic [8:0]              quo_reg, quo_next;
    logic [6:0]              div_reg, div_next;
    logic [3:0]              cnt_reg, cnt_next;
    logic [9:0]              max_rto_reg, max_rto_next;
    logic [3:0]              dup_lim_reg, dup_lim_next;
    logic [6:0]              min_sst_reg, min_sst_next;
    logic                    mv_reg, mv_next;
    logic [14:0]             o_cwnd_reg, o_cwnd_next;
    logic [6:0]              o_thr_reg, o_thr_next;
    logic [15:0]             o_rto_reg, o_rto_next;
    logic                    o_rex_reg, o_rex_next;
    logic [31:0]             o_rseq_reg, o_rseq_next;
    logic [6:0]              o_infl_reg, o_infl_next;
    logic                    o_may_reg, o_may_next;
    logic                    o_stat_reg, o_stat_next;

    logic        ram_we;
    logic [31:0] rd_seq, rd_time;

    logic [15:0] ela_inc;
    logic [3:0]  dup_inc;
    logic [6:0]  half_w;
    logic [6:0]  rex_thr;
    logic [31:0] diff;
    logic [15:0] smp;
    logic [17:0] dev_sum;
    logic [18:0] srtt_sum;
    logic [18:0] rto_sum;
    logic [15:0] rto_cap;
    logic [8:0]  rem_sh;
    logic [15:0] win_sum;
    logic [6:0]  whole;

    tcwc_ram #(.WIDTH(32), .DEPTH(WINDOW_SLOTS)) u_seq_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (val_reg),
        .raddr (idx_reg),
        .rdata (rd_seq)
    );

    tcwc_ram #(.WIDTH(32), .DEPTH(WINDOW_SLOTS)) u_time_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (idx_reg),
        .wdata (now_reg),
        .raddr (idx_reg),
        .rdata (rd_time)
    );

    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    assign ela_inc  = (ela_reg == 16'hFFFF) ? ela_reg : ela_reg + 16'd1;
    assign dup_inc  = (dup_reg == 4'hF) ? dup_reg : dup_reg + 4'd1;
    assign half_w   = {1'b0, win_reg[14:9]};
    assign rex_thr  = (half_w > min_sst_reg) ? half_w : min_sst_reg;
    assign diff     = now_reg - sent_reg;
    assign smp      = (diff > 32'd1023) ? 16'hFFFF : {diff[9:0], 6'b0};
    assign dev_sum  = {2'b0, dev_reg} + {1'b0, dev_reg, 1'b0} + {2'b0, err_reg};
    assign srtt_sum = {srtt_reg, 3'b0} - {3'b0, srtt_reg} + {3'b0, smp_reg};
    assign rto_sum  = ({3'b0, srtt_reg} + {1'b0, dev_reg, 2'b0}) & ~19'd63;
    assign rto_cap  = {max_rto_reg, 6'b0};
    assign rem_sh   = {rem_reg[7:0], (cnt_reg == 4'd9)};
    assign win_sum  = {1'b0, win_reg} + {7'b0, quo_reg};
    assign whole    = win_reg[14:8];

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        valid_next    = valid_reg;
        val_next      = val_reg;
        now_next      = now_reg;
        win_next      = win_reg;
        thr_next      = thr_reg;
        srtt_next     = srtt_reg;
        dev_next      = dev_reg;
        rto_next      = rto_reg;
        dup_next      = dup_reg;
        hack_next     = hack_reg;
        run_next      = run_reg;
        ela_next      = ela_reg;
        old_next      = old_reg;
        outst_next    = outst_reg;
        match_next    = match_reg;
        rex_next      = rex_reg;
        stat_next     = stat_reg;
        sent_next     = sent_reg;
        smp_next      = smp_reg;
        err_next      = err_reg;
        rem_next      = rem_reg;
        quo_next      = quo_reg;
        div_next      = div_reg;
        cnt_next      = cnt_reg;
        max_rto_next  = max_rto_reg;
        dup_lim_next  = dup_lim_reg;
        min_sst_next  = min_sst_reg;
        mv_next       = mv_reg;
        o_cwnd_next   = o_cwnd_reg;
        o_thr_next    = o_thr_reg;
        o_rto_next    = o_rto_reg;
        o_rex_next    = o_rex_reg;
        o_rseq_next   = o_rseq_reg;
        o_infl_next   = o_infl_reg;
        o_may_next    = o_may_reg;
        o_stat_next   = o_stat_reg;
        ram_we        = 1'b0;

        if (mv_reg && m_ready) begin
            mv_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    val_next   = s_seq_value;
                    rex_next   = 1'b0;
                    stat_next  = 1'b0;
                    idx_next   = '0;
                    match_next = 1'b0;
                    state_next = ST_OUT;
                    unique case (s_command)
                        CMD_SEND: begin
                            state_next = ST_SCAN;
                        end
                        CMD_ACK: begin
                            if (s_seq_value > hack_reg) begin
                                run_next   = 1'b0;
                                hack_next  = s_seq_value;
                                dup_next   = '0;
                                state_next = ST_RD;
                            end else begin
                                dup_next = dup_inc;
                                if (dup_inc >= dup_lim_reg && run_reg) begin
                                    thr_next = rex_thr;
                                    win_next = ONE_SEGMENT;
                                    dup_next = '0;
                                    ela_next = '0;
                                    rex_next = 1'b1;
                                end
                            end
                        end
                        CMD_TICK: begin
                            now_next = now_reg + 32'd1;
                            if (run_reg) begin
                                ela_next = ela_inc;
                                if ({ela_inc, 6'b0} >= {6'b0, rto_reg}) begin
                                    thr_next = rex_thr;
                                    win_next = ONE_SEGMENT;
                                    dup_next = '0;
                                    ela_next = '0;
                                    rex_next = 1'b1;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_SCAN: begin
                if (!valid_reg[idx_reg]) begin
                    ram_we              = 1'b1;
                    valid_next[idx_reg] = 1'b1;
                    outst_next          = outst_reg + 7'd1;
                    if (!run_reg) begin
                        run_next = 1'b1;
                        ela_next = '0;
                        old_next = val_reg;
                    end
                    state_next = ST_OUT;
                end else if (idx_reg == IDX_LAST) begin
                    stat_next  = 1'b1;
                    state_next = ST_OUT;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_RD: begin
                state_next = ST_CHK;
            end
            ST_CHK: begin
                if (valid_reg[idx_reg] && rd_seq < val_reg) begin
                    sent_next           = rd_time;
                    valid_next[idx_reg] = 1'b0;
                    if (outst_reg != 7'd0) begin
                        outst_next = outst_reg - 7'd1;
                    end
                    state_next = ST_ERR;
                end else begin
                    if (valid_reg[idx_reg] && rd_seq == val_reg) begin
                        match_next = 1'b1;
                    end
                    if (idx_reg == IDX_LAST) begin
                        state_next = ST_END;
                    end else begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = ST_RD;
                    end
                end
            end
            ST_ERR: begin
                smp_next   = smp;
                err_next   = (smp > srtt_reg) ? smp - srtt_reg : srtt_reg - smp;
                state_next = ST_UPD;
            end
            ST_UPD: begin
                dev_next   = dev_sum[17:2];
                srtt_next  = srtt_sum[18:3];
                state_next = ST_RTO;
            end
            ST_RTO: begin
                rto_next   = (rto_sum < {3'b0, rto_cap}) ? rto_sum[15:0] : rto_cap;
                state_next = ST_GROW;
            end
            ST_GROW: begin
                if (whole < thr_reg) begin
                    quo_next   = 9'd256;
                    state_next = ST_GADD;
                end else begin
                    rem_next   = '0;
                    quo_next   = '0;
                    cnt_next   = 4'd9;
                    div_next   = (whole == 7'd0) ? 7'd1 : whole;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (rem_sh >= {2'b0, div_reg}) begin
                    rem_next = rem_sh - {2'b0, div_reg};
                    quo_next = {quo_reg[7:0], 1'b1};
                end else begin
                    rem_next = rem_sh;
                    quo_next = {quo_reg[7:0], 1'b0};
                end
                cnt_next = cnt_reg - 4'd1;
                if (cnt_reg == 4'd1) begin
                    state_next = ST_GADD;
                end
            end
            ST_GADD: begin
                win_next = (win_sum > WIN_CAP) ? WIN_CAP[14:0] : win_sum[14:0];
                if (idx_reg == IDX_LAST) begin
                    state_next = ST_END;
                end else begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_RD;
                end
            end
            ST_END: begin
                if (match_reg) begin
                    run_next = 1'b1;
                    ela_next = '0;
                    old_next = val_reg;
                end
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!mv_reg || m_ready) begin
                    mv_next     = 1'b1;
                    o_cwnd_next = win_reg;
                    o_thr_next  = thr_reg;
                    o_rto_next  = rto_reg;
                    o_rex_next  = rex_reg;
                    o_rseq_next = rex_reg ? old_reg : 32'd0;
                    o_infl_next = outst_reg;
                    o_may_next  = (outst_reg < win_reg[14:8]);
                    o_stat_next = stat_reg;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_valid) begin
            unique case (cfg_index)
                REG_MAX_RTO:  max_rto_next = cfg_data;
                REG_INIT_RTO: rto_next     = {cfg_data, 6'b0};
                REG_DUP_LIM:  dup_lim_next = cfg_data[3:0];
                REG_MIN_SST:  min_sst_next = cfg_data[6:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            idx_reg      <= '0;
            valid_reg    <= '0;
            now_reg      <= '0;
            win_reg      <= ONE_SEGMENT;
            thr_reg      <= RST_THRESH;
            srtt_reg     <= '0;
            dev_reg      <= '0;
            rto_reg      <= {RST_INIT_RTO, 6'b0};
            dup_reg      <= '0;
            hack_reg     <= '0;
            run_reg      <= 1'b0;
            ela_reg      <= '0;
            old_reg      <= '0;
            outst_reg    <= '0;
            match_reg    <= 1'b0;
            rex_reg      <= 1'b0;
            stat_reg     <= 1'b0;
            cnt_reg      <= '0;
            max_rto_reg  <= RST_MAX_RTO;
            dup_lim_reg  <= RST_DUP_LIM;
            min_sst_reg  <= RST_MIN_SST;
            mv_reg       <= 1'b0;
        end else begin
            state_reg    <= state_next;
            idx_reg      <= idx_next;
            valid_reg    <= valid_next;
            now_reg      <= now_next;
            win_reg      <= win_next;
            thr_reg      <= thr_next;
            srtt_reg     <= srtt_next;
            dev_reg      <= dev_next;
            rto_reg      <= rto_next;
            dup_reg      <= dup_next;
            hack_reg     <= hack_next;
            run_reg      <= run_next;
            ela_reg      <= ela_next;
            old_reg      <= old_next;
            outst_reg    <= outst_next;
            match_reg    <= match_next;
            rex_reg      <= rex_next;
            stat_reg     <= stat_next;
            cnt_reg      <= cnt_next;
            max_rto_reg  <= max_rto_next;
            dup_lim_reg  <= dup_lim_next;
            min_sst_reg  <= min_sst_next;
            mv_reg       <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        val_reg    <= val_next;
        sent_reg   <= sent_next;
        smp_reg    <= smp_next;
        err_reg    <= err_next;
        rem_reg    <= rem_next;
        quo_reg    <= quo_next;
        div_reg    <= div_next;
        o_cwnd_reg <= o_cwnd_next;
        o_thr_reg  <= o_thr_next;
        o_rto_reg  <= o_rto_next;
        o_rex_reg  <= o_rex_next;
        o_rseq_reg <= o_rseq_next;
        o_infl_reg <= o_infl_next;
        o_may_reg  <= o_may_next;
        o_stat_reg <= o_stat_next;
    end

    assign m_valid                = mv_reg;
    assign m_cwnd_fixed           = o_cwnd_reg;
    assign m_slow_start_threshold = o_thr_reg;
    assign m_rto_fixed            = o_rto_reg;
    assign m_retransmit           = o_rex_reg;
    assign m_retransmit_seqno     = o_rseq_reg;
    assign m_in_flight            = o_infl_reg;
    assign m_may_send             = o_may_reg;
    assign m_status               = o_stat_reg;

endmodule

FILE: rtl/core/tcwc_checker.sv
// ----------------------------------------------------------------------------
// tcwc_checker
// Port-level checks on the result channel of the window controller.
// ----------------------------------------------------------------------------
module tcwc_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_valid,
    input logic        m_ready,
    input logic [14:0] m_cwnd_fixed,
    input logic        m_retransmit,
    input logic [31:0] m_retransmit_seqno,
    input logic [6:0]  m_in_flight,
    input logic        m_may_send,
    input logic        m_status
);
    import tcwc_pkg::*;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_cwnd_fixed) && $stable(m_in_flight))
        else $error("result beat changed while stalled");

    a_rex_win: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_retransmit |-> m_cwnd_fixed == 15'd256)
        else $error("retransmit without window collapse");

    a_rex_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_retransmit |-> m_retransmit_seqno == 32'd0)
        else $error("stray retransmit sequence number");

    a_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status |-> m_in_flight == 7'(WINDOW_SLOTS))
        else $error("drop flagged with table not full");

    a_may: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_may_send == (m_in_flight < m_cwnd_fixed[14:8]))
        else $error("may_send disagrees with window");

endmodule

bind tcp_congestion_window_controller tcwc_checker u_tcwc_checker (
    .aclk               (aclk),
    .aresetn            (aresetn),
    .m_valid            (m_valid),
    .m_ready            (m_ready),
    .m_cwnd_fixed       (m_cwnd_fixed),
    .m_retransmit       (m_retransmit),
    .m_retransmit_seqno (m_retransmit_seqno),
    .m_in_flight        (m_in_flight),
    .m_may_send         (m_may_send),
    .m_status           (m_status)
);
